[rtl/core/bba_pkg.sv]
package bba_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int SLOT_SPAN   = 65536;

  localparam int SLOT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W  = 17;
  localparam int ADDR_W = 20;

  localparam logic [CNT_W-1:0] BSIZE_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  // capacity of a shared bucket never exceeds the span of one slot
  localparam logic [CNT_W-1:0] SPAN_CAP =
      (SLOT_SPAN > (2 ** CNT_W) - 1) ? CNT_MAX : CNT_W'(SLOT_SPAN);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_TOO_BIG   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] alloc;
    logic [CNT_W-1:0] freed;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic              valid;
    slot_t             data;
  } slot_wr_t;

  function automatic logic [ADDR_W-1:0] make_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [CNT_W-1:0]  off);
    logic [63:0] t;
    t = 64'(slot) * 64'(SLOT_SPAN) + 64'(off);
    return t[ADDR_W-1:0];
  endfunction

endpackage

[rtl/core/bucket_bump_allocator_unit.sv]
// Channel  | Dir | Handshake              | Payload
// in_      | in  | in_tvalid / in_tready  | tuser: req_type; tdata: count, address
// out_     | out | out_tvalid / out_tready| tdata: granted_address, status
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_data: bucket_size
//
// One word at a time. Too-large and dedicated allocates go from decode straight to the result;
// deallocate adds a free step; small allocate adds the slot scan
// through the shared fit/add unit, one slot per cycle (up to 16).
// The result sits in an output register, so a new word is taken while it waits.
// rst_n is synchronous: slot table empty, bucket_size back to 1024.
// A stalled output holds only the last result; the next one waits in its state.
module bucket_bump_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,  // count[16:0], address[36:17], zero
  input  logic [0:0]                  in_tuser,  // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata, // granted_address[19:0], status[21:20]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_data
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FREE   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              req_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  bsize_r;

  slot_t                  rd_data;
  logic                   rd_valid;
  logic [NUM_BUCKETS-1:0] valid_vec;
  slot_wr_t               wr;
  logic                   fits;
  logic [CNT_W:0]         sum;

  logic [SLOT_W-1:0] free_idx;
  logic              free_any;
  logic [ADDR_W-1:0] addr_slot;
  logic [ADDR_W-1:0] addr_off;
  logic              too_big;
  logic [CNT_W-1:0]  shared_cap;
  logic [CNT_W-1:0]  freed_sat;
  logic              in_acc;
  logic              out_load;

  bba_slot_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .rd_data   (rd_data),
    .rd_valid  (rd_valid),
    .valid_vec (valid_vec),
    .wr        (wr)
  );

  bba_arith u_arith (
    .slot      (rd_data),
    .cnt       (cnt_r),
    .use_freed (state_r == S_FREE),
    .fits      (fits),
    .sum       (sum)
  );

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign addr_slot  = ADDR_W'(addr_r / SLOT_SPAN);
  assign addr_off   = ADDR_W'(addr_r % SLOT_SPAN);
  assign too_big    = 32'(cnt_r) > 32'(SLOT_SPAN);
  assign shared_cap = (32'(bsize_r) > 32'(SLOT_SPAN)) ? SPAN_CAP : bsize_r;
  assign freed_sat  = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    wr             = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_addr_nxt   = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
        if (req_r == REQ_FREE) begin
          if (32'(addr_slot) < 32'(NUM_BUCKETS)) begin
            idx_nxt   = addr_slot[SLOT_W-1:0];
            state_nxt = S_FREE;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end else if (too_big) begin
          res_status_nxt = ST_TOO_BIG;
        end else if (cnt_r > bsize_r) begin
          // dedicated bucket of exactly the requested size
          if (free_any) begin
            wr.en        = 1'b1;
            wr.idx       = free_idx;
            wr.valid     = 1'b1;
            wr.data      = '{cap: cnt_r, alloc: cnt_r, freed: '0};
            res_addr_nxt = make_addr(free_idx, '0);
          end else begin
            res_status_nxt = ST_NO_SLOT;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_valid && fits) begin
          wr.en        = 1'b1;
          wr.idx       = idx_r;
          wr.valid     = 1'b1;
          wr.data      = '{cap: rd_data.cap, alloc: sum[CNT_W-1:0], freed: rd_data.freed};
          res_addr_nxt = make_addr(idx_r, rd_data.alloc);
          state_nxt    = S_DONE;
        end else if (idx_r == SLOT_W'(NUM_BUCKETS - 1)) begin
          // no room anywhere: open a new shared bucket
          if (free_any) begin
            wr.en        = 1'b1;
            wr.idx       = free_idx;
            wr.valid     = 1'b1;
            wr.data      = '{cap: shared_cap, alloc: cnt_r, freed: '0};
            res_addr_nxt = make_addr(free_idx, '0);
          end else begin
            res_status_nxt = ST_NO_SLOT;
          end
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FREE: begin
        if (rd_valid && (32'(addr_off) < 32'(rd_data.alloc))) begin
          wr.en    = 1'b1;
          wr.idx   = idx_r;
          wr.valid = (freed_sat != rd_data.alloc);
          wr.data  = '{cap: rd_data.cap, alloc: rd_data.alloc, freed: freed_sat};
        end else begin
          res_status_nxt = ST_NOT_FOUND;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bsize_r     <= BSIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bsize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      req_r  <= in_tuser[0];
      cnt_r  <= in_tdata[CNT_W-1:0];
      addr_r <= in_tdata[CNT_W+ADDR_W-1:CNT_W];
    end
    if (out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_addr_r};

endmodule

[rtl/core/bba_slot_table.sv]
module bba_slot_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bba_pkg::SLOT_W-1:0]   rd_idx,
  output bba_pkg::slot_t               rd_data,
  output logic                         rd_valid,
  output logic [bba_pkg::NUM_BUCKETS-1:0] valid_vec,
  input  bba_pkg::slot_wr_t            wr
);
  import bba_pkg::*;

  logic [NUM_BUCKETS-1:0] valid_r;
  slot_t                  slot_r [NUM_BUCKETS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data   = slot_r[rd_idx];
  assign rd_valid  = valid_r[rd_idx];
  assign valid_vec = valid_r;

endmodule

[rtl/core/bba_arith.sv]
module bba_arith (
  input  bba_pkg::slot_t             slot,
  input  logic [bba_pkg::CNT_W-1:0]  cnt,
  input  logic                       use_freed,
  output logic                       fits,
  output logic [bba_pkg::CNT_W:0]    sum
);
  import bba_pkg::*;

  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] base;

  // room left in the bucket; only meaningful when cap >= alloc
  assign room = slot.cap - slot.alloc;
  assign fits = (slot.cap >= slot.alloc) && (room >= cnt);

  assign base = use_freed ? slot.freed : slot.alloc;
  assign sum  = {1'b0, base} + {1'b0, cnt};

endmodule

[rtl/core/bba_checker.sv]
module bba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // any error status comes with a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[21:20] != 2'd0) |-> out_tdata[19:0] == 20'd0)
    else $error("error status with nonzero address");

  // block works on one word at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // no result straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bucket_bump_allocator_unit bba_checker u_bba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/bba_grant_checker.sv]
module bba_grant_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [39:0]                in_tdata,   // count[16:0], address[36:17], zero
  input  logic [0:0]                 in_tuser,   // req_type
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [23:0]                out_tdata,  // granted_address[19:0], status[21:20]
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_data,
  output int                         fails,
  output int                         grants_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } grant_t;

  grant_t           expected_grants[$];
  logic             live  [NUM_BUCKETS];
  logic [CNT_W-1:0] cap   [NUM_BUCKETS];
  logic [CNT_W-1:0] used  [NUM_BUCKETS];
  logic [CNT_W-1:0] freed [NUM_BUCKETS];
  logic [CNT_W-1:0] bsize;
  grant_t           got;
  grant_t           want;

  function automatic int lowest_open();
    int s;
    s = -1;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) if (!live[i]) s = i;
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(int s, logic [CNT_W-1:0] off);
    logic [63:0] a;
    a = 64'(s) * 64'(SLOT_SPAN) + 64'(off);
    return a[ADDR_W-1:0];
  endfunction

  // updates the slot table copy and returns the word the block should answer
  function automatic grant_t predict_grant(logic req, logic [CNT_W-1:0] cnt,
                                           logic [ADDR_W-1:0] adr);
    grant_t           g;
    int               s;
    logic [CNT_W-1:0] new_cap;
    logic [CNT_W:0]   sum;
    longint unsigned  sl;
    longint unsigned  off;
    g.addr   = '0;
    g.status = ST_OK;
    if (req == REQ_ALLOC) begin
      if (cnt > SLOT_SPAN) begin
        g.status = ST_TOO_BIG;
      end else if (cnt > bsize) begin
        s = lowest_open();
        if (s < 0) begin
          g.status = ST_NO_SLOT;
        end else begin
          live[s]  = 1'b1;
          cap[s]   = cnt;
          used[s]  = cnt;
          freed[s] = '0;
          g.addr   = slot_addr(s, '0);
        end
      end else begin
        // lowest slot with room wins
        s = -1;
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
          if (live[i] && cap[i] >= used[i] && cap[i] - used[i] >= cnt) s = i;
        if (s >= 0) begin
          g.addr  = slot_addr(s, used[s]);
          used[s] = used[s] + cnt;
        end else begin
          s = lowest_open();
          if (s < 0) begin
            g.status = ST_NO_SLOT;
          end else begin
            new_cap  = (bsize > SLOT_SPAN) ? SPAN_CAP : bsize;
            live[s]  = 1'b1;
            cap[s]   = new_cap;
            used[s]  = cnt;
            freed[s] = '0;
            g.addr   = slot_addr(s, '0);
          end
        end
      end
    end else begin
      sl  = adr / SLOT_SPAN;
      off = adr % SLOT_SPAN;
      if (sl < NUM_BUCKETS && live[sl] && off < used[sl]) begin
        sum = freed[sl] + cnt;
        if (sum > CNT_MAX) sum = CNT_MAX;
        freed[sl] = sum[CNT_W-1:0];
        if (freed[sl] == used[sl]) live[sl] = 1'b0;
      end else begin
        g.status = ST_NOT_FOUND;
      end
    end
    return g;
  endfunction

  initial begin
    fails       = 0;
    grants_owed = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) live[i] = 1'b0;
      bsize = BSIZE_RESET;
      expected_grants.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.addr   = out_tdata[ADDR_W-1:0];
        got.status = status_t'(out_tdata[ADDR_W+1:ADDR_W]);
        if (expected_grants.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, address %05h status %0d",
                   $time, got.addr, got.status);
        end else begin
          want = expected_grants.pop_front();
          if (got.addr !== want.addr) begin
            fails++;
            $display("%0t: granted_address expected %05h got %05h",
                     $time, want.addr, got.addr);
          end
          if (got.status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) bsize = cfg_data;
      if (in_tvalid && in_tready)
        expected_grants = {expected_grants,
                           predict_grant(in_tuser[0], in_tdata[CNT_W-1:0],
                                         in_tdata[CNT_W+ADDR_W-1:CNT_W])};
    end
    grants_owed = expected_grants.size();
  end

endmodule

[bench/bucket_bump_allocator_unit_tb.sv]
module bucket_bump_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int RUN_LIMIT = 600000;
  localparam int PER_PHASE = 141;
  localparam int NUM_PHASES = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [39:0]       in_tdata;   // count[16:0], address[36:17], zero
  logic [0:0]        in_tuser;   // req_type
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // granted_address[19:0], status[21:20]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  int                fails;
  int                grants_owed;
  int                src_idle;
  int                sink_stall;
  int                cycles;
  bit                hold_off;
  logic [CNT_W-1:0]  bsize_now;

  // requests in flight, and allocations we own and may hand back
  logic              sent_req[$];
  logic [CNT_W-1:0]  sent_cnt[$];
  logic [ADDR_W-1:0] live_addr[$];
  logic [CNT_W-1:0]  live_cnt[$];
  logic              mon_req;
  logic [CNT_W-1:0]  mon_cnt;

  bucket_bump_allocator_unit dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  bba_grant_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_data,
    .fails(fails), .grants_owed(grants_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("bucket_bump_allocator_unit: mismatch");
      $finish;
    end
  end

  // learn granted blocks so frees can target them
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && sent_req.size() != 0) begin
      mon_req = sent_req.pop_front();
      mon_cnt = sent_cnt.pop_front();
      if (mon_req == REQ_ALLOC && out_tdata[21:20] == ST_OK && mon_cnt != 0) begin
        live_addr = {live_addr, out_tdata[ADDR_W-1:0]};
        live_cnt  = {live_cnt, mon_cnt};
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      sent_req = {sent_req, in_tuser[0]};
      sent_cnt = {sent_cnt, in_tdata[CNT_W-1:0]};
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= sink_stall);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic offer(input logic req, input logic [CNT_W-1:0] cnt,
                       input logic [ADDR_W-1:0] adr);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {3'b000, adr, cnt};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (grants_owed != 0 || sent_req.size() != 0) @(negedge clk);
  endtask

  task automatic write_bsize(input logic [CNT_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    bsize_now = v;
  endtask

  task automatic random_word();
    int                pick;
    int                k;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  c;
    logic [CNT_W-1:0]  part;
    logic [ADDR_W-1:0] a;
    lim  = (bsize_now > SLOT_SPAN) ? SPAN_CAP : bsize_now;
    pick = $urandom_range(199);
    if (pick >= 100 && pick < 180 && live_cnt.size() == 0) pick = 0;
    if (pick >= 80 && pick < 100 && bsize_now >= SLOT_SPAN) pick = 0;
    if (pick < 80) begin
      c = $urandom_range(1) ? CNT_W'($urandom_range(lim)) : CNT_W'($urandom_range(lim >> 4));
      offer(REQ_ALLOC, c, ADDR_W'($urandom));
    end else if (pick < 100) begin
      k = bsize_now + 256;
      if (k > SLOT_SPAN) k = SLOT_SPAN;
      if ($urandom_range(1)) c = CNT_W'($urandom_range(SLOT_SPAN, bsize_now + 1));
      else c = CNT_W'($urandom_range(k, bsize_now + 1));
      offer(REQ_ALLOC, c, ADDR_W'($urandom));
    end else if (pick < 180) begin
      // hand back an owned block, sometimes only part of it
      k = $urandom_range(live_cnt.size() - 1);
      c = live_cnt[k];
      a = live_addr[k] + ADDR_W'($urandom_range(c - 1));
      if (c > 1 && $urandom_range(3) == 0) begin
        part        = CNT_W'($urandom_range(c - 1, 1));
        live_cnt[k] = c - part;
        c           = part;
      end else begin
        live_cnt.delete(k);
        live_addr.delete(k);
      end
      offer(REQ_FREE, c, a);
    end else if (pick < 188) begin
      offer(REQ_ALLOC, CNT_W'($urandom_range(CNT_MAX, SLOT_SPAN + 1)), ADDR_W'($urandom));
    end else if (pick < 199) begin
      offer(1'($urandom), CNT_W'($urandom), ADDR_W'($urandom));
    end else begin
      // over-release: freed count saturates and the slot never drains
      a = (live_addr.size() != 0) ? live_addr[0] : ADDR_W'($urandom);
      offer(REQ_FREE, CNT_MAX, a);
    end
  endtask

  // addresses below assume 64K elements per slot
  task automatic directed_part();
    offer(REQ_ALLOC, 0, '0);              // zero count opens a shared bucket
    offer(REQ_ALLOC, 1024, 20'h12345);    // fills slot 0 exactly
    offer(REQ_ALLOC, 1025, '0);           // dedicated bucket in slot 1
    offer(REQ_ALLOC, SLOT_SPAN + 1, '0);
    offer(REQ_ALLOC, CNT_MAX, '1);
    offer(REQ_FREE, 0, '1);               // slot 15 not in use
    offer(REQ_FREE, 5, 20'h10401);        // offset just past the allocated elements
    offer(REQ_FREE, 1025, 20'h10000);     // releases slot 1
    offer(REQ_FREE, 1, 20'h003FF);
    offer(REQ_FREE, CNT_MAX, 20'h00000);  // over-release of slot 0
    settle();
    live_addr.delete();
    live_cnt.delete();
    offer(REQ_ALLOC, SLOT_SPAN, '1);
    repeat (14) offer(REQ_ALLOC, CNT_W'($urandom_range(SLOT_SPAN - 1, 1025)),
                      ADDR_W'($urandom));
    offer(REQ_ALLOC, 1, '0);              // table full on the shared path
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    bsize_now = BSIZE_RESET;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    directed_part();
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 61; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 61; end
        default: begin src_idle = 29; sink_stall = 29; end
      endcase
      case (p)
        1: write_bsize(0);
        2: write_bsize(1);
        3: write_bsize(SLOT_SPAN);
        4: write_bsize(CNT_MAX);
        5: write_bsize(37);
        6: write_bsize(4096);
        7: write_bsize(BSIZE_RESET);
        default: ;
      endcase
      if (p == 4) hold_off = 1'b1;
      repeat (PER_PHASE) random_word();
    end
    settle();
    repeat (40) @(negedge clk);
    if (fails == 0 && grants_owed == 0) begin
      $display("bucket_bump_allocator_unit: match");
    end else begin
      $display("bucket_bump_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
